// ===== design/hrsp_pkg.sv =====
// Shared types, constants and pattern tables for the request stream parser.
package hrsp_pkg;

	localparam int MaxRequestBytesDef = 2048;
	localparam int MaxBodyLengthDef   = 1048575;

	localparam logic [1:0] EV_URL  = 2'd0;
	localparam logic [1:0] EV_BODY = 2'd1;
	localparam logic [1:0] EV_DONE = 2'd2;
	localparam logic [1:0] EV_BAD  = 2'd3;

	typedef struct packed {
		logic       new_connection;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  payload_byte;
		logic        is_post;
		logic        keep_alive;
		logic [19:0] body_length;
	} out_item_t;

	// Byte queued between front and back: byte plus its line-end and blank class and lower-case form.
	typedef struct packed {
		logic       new_conn;
		logic [7:0] data;
		logic       is_cr;
		logic       is_lf;
		logic       is_blank;
		logic [7:0] low;
	} cls_item_t;

	function automatic logic [7:0] pat_get(input logic [3:0] i);
		case (i)
			4'd0: pat_get = "g";
			4'd1: pat_get = "e";
			4'd2: pat_get = "t";
			default: pat_get = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_post(input logic [3:0] i);
		case (i)
			4'd0: pat_post = "p";
			4'd1: pat_post = "o";
			4'd2: pat_post = "s";
			4'd3: pat_post = "t";
			default: pat_post = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_ver(input logic [3:0] i);
		case (i)
			4'd0: pat_ver = "h";
			4'd1: pat_ver = "t";
			4'd2: pat_ver = "t";
			4'd3: pat_ver = "p";
			4'd4: pat_ver = "/";
			4'd5: pat_ver = "1";
			4'd6: pat_ver = ".";
			4'd7: pat_ver = "1";
			default: pat_ver = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_scheme(input logic [3:0] i);
		case (i)
			4'd0: pat_scheme = "h";
			4'd1: pat_scheme = "t";
			4'd2: pat_scheme = "t";
			4'd3: pat_scheme = "p";
			4'd4: pat_scheme = "s";
			4'd5: pat_scheme = ":";
			4'd6: pat_scheme = "/";
			4'd7: pat_scheme = "/";
			default: pat_scheme = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_conn(input logic [3:0] i);
		case (i)
			4'd0: pat_conn = "c";
			4'd1: pat_conn = "o";
			4'd2: pat_conn = "n";
			4'd3: pat_conn = "n";
			4'd4: pat_conn = "e";
			4'd5: pat_conn = "c";
			4'd6: pat_conn = "t";
			4'd7: pat_conn = "i";
			4'd8: pat_conn = "o";
			4'd9: pat_conn = "n";
			4'd10: pat_conn = ":";
			default: pat_conn = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_clen(input logic [3:0] i);
		case (i)
			4'd0: pat_clen = "c";
			4'd1: pat_clen = "o";
			4'd2: pat_clen = "n";
			4'd3: pat_clen = "t";
			4'd4: pat_clen = "e";
			4'd5: pat_clen = "n";
			4'd6: pat_clen = "t";
			4'd7: pat_clen = "-";
			4'd8: pat_clen = "l";
			4'd9: pat_clen = "e";
			4'd10: pat_clen = "n";
			4'd11: pat_clen = "g";
			4'd12: pat_clen = "t";
			4'd13: pat_clen = "h";
			4'd14: pat_clen = ":";
			default: pat_clen = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_keep(input logic [3:0] i);
		case (i)
			4'd0: pat_keep = "k";
			4'd1: pat_keep = "e";
			4'd2: pat_keep = "e";
			4'd3: pat_keep = "p";
			4'd4: pat_keep = "-";
			4'd5: pat_keep = "a";
			4'd6: pat_keep = "l";
			4'd7: pat_keep = "i";
			4'd8: pat_keep = "v";
			4'd9: pat_keep = "e";
			default: pat_keep = 8'h00;
		endcase
	endfunction

endpackage

// ===== design/hrsp_front.sv =====
// Front stage: accepts request bytes, classifies them and fills a two-entry queue.
module hrsp_front
	import hrsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      q_valid,
	input  logic      q_pop,
	output cls_item_t q_data
);

	cls_item_t ent_q [2];
	logic      rd_q, wr_q;
	logic [1:0] cnt_q;
	cls_item_t cls;
	logic      push;

	always_comb begin
		cls.new_conn = in_data.new_connection;
		cls.data     = in_data.data_byte;
		cls.is_cr    = in_data.data_byte == 8'h0D;
		cls.is_lf    = in_data.data_byte == 8'h0A;
		cls.is_blank = in_data.data_byte == 8'h20 || in_data.data_byte == 8'h09;
		cls.low      = (in_data.data_byte >= "A" && in_data.data_byte <= "Z")
			? in_data.data_byte + 8'd32 : in_data.data_byte;
	end

	assign in_stall = cnt_q == 2'd2;
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_data   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> in_stall) else $error("full queue not stalling");

endmodule

// ===== design/hrsp_back.sv =====
// Back stage: request parsing state machine with an output register.
module hrsp_back
	import hrsp_pkg::*;
#(
	parameter int MAX_REQUEST_BYTES = MaxRequestBytesDef,
	parameter int MAX_BODY_LENGTH   = MaxBodyLengthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_pop,
	input  cls_item_t q_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int CW = $clog2(MAX_REQUEST_BYTES + 1);
	localparam logic [2:0] PH_LINE = 3'd0;
	localparam logic [2:0] PH_HEAD = 3'd1;
	localparam logic [2:0] PH_BODY = 3'd2;
	localparam logic [2:0] PH_FIN  = 3'd3;
	localparam logic [19:0] MaxLen = 20'(MAX_BODY_LENGTH > 1048575 ? 1048575 : MAX_BODY_LENGTH);

	logic [2:0]  ph_q, tp_q;
	logic [3:0]  mp_q;
	logic [1:0]  hk_q;
	logic        cr_q, post_q, ka_q;
	logic [19:0] clen_q, rem_q;
	logic [CW-1:0] cnt_q;

	logic [2:0]  ph, tp;
	logic [3:0]  mp;
	logic [1:0]  hk;
	logic        cr, post, ka;
	logic [19:0] clen, rem;
	logic [CW-1:0] cnt;
	logic        emit;
	logic [1:0]  kind;
	logic [7:0]  pay;
	logic [7:0]  b, lb;
	logic        bl;
	logic [3:0]  mlen;
	logic [7:0]  mpat;
	logic [23:0] prod;
	logic [3:0]  hlen;
	logic [7:0]  hpat;

	logic out_valid_q;
	out_item_t out_q;

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		b  = q_data.data;
		lb = q_data.low;
		bl = q_data.is_blank;
		ph = ph_q; tp = tp_q; mp = mp_q; hk = hk_q; cr = cr_q;
		post = post_q; ka = ka_q; clen = clen_q; rem = rem_q; cnt = cnt_q;
		emit = 1'b0; kind = EV_BAD; pay = 8'h00;
		mlen = 4'd0; mpat = 8'h00; prod = 24'd0; hlen = 4'd0; hpat = 8'h00;
		if (q_data.new_conn) begin
			ph = PH_LINE; tp = 3'd0; mp = 4'd0; hk = 2'd0; cr = 1'b0;
			post = 1'b0; ka = 1'b0; clen = 20'd0; rem = 20'd0; cnt = '0;
		end
		mlen = post ? 4'd4 : 4'd3;
		mpat = post ? pat_post(mp) : pat_get(mp);
		if (ph == PH_FIN) begin
			// drop bytes until a new connection
		end else if (cnt >= CW'(MAX_REQUEST_BYTES)) begin
			ph = PH_FIN; emit = 1'b1; kind = EV_BAD;
		end else begin
			cnt = cnt + 1'b1;
			if (ph == PH_BODY) begin
				if (rem != 20'd0) rem = rem - 20'd1;
				emit = 1'b1; pay = b;
				if (rem == 20'd0) begin
					ph = PH_FIN; kind = EV_DONE;
				end else kind = EV_BODY;
			end else if (cr) begin
				cr = 1'b0;
				if (!q_data.is_lf) begin
					ph = PH_FIN; emit = 1'b1; kind = EV_BAD;
				end else if (ph == PH_LINE) begin
					if (tp != 3'd6 || mp != 4'd8) begin
						ph = PH_FIN; emit = 1'b1; kind = EV_BAD;
					end else begin
						ph = PH_HEAD; tp = 3'd0; mp = 4'd0; hk = 2'd0;
					end
				end else if (tp == 3'd0 && mp == 4'd0 && hk == 2'd0) begin
					if (clen == 20'd0) begin
						ph = PH_FIN; emit = 1'b1; kind = EV_DONE;
					end else begin
						rem = clen; ph = PH_BODY;
					end
				end else begin
					if (hk == 2'd1 && tp == 3'd2 && mp == 4'd10) ka = 1'b1;
					tp = 3'd0; mp = 4'd0; hk = 2'd0;
				end
			end else if (q_data.is_cr) begin
				cr = 1'b1;
			end else if (q_data.is_lf) begin
				ph = PH_FIN; emit = 1'b1; kind = EV_BAD;
			end else if (ph == PH_LINE) begin
				case (tp)
					3'd0: begin
						if (bl) begin
							if (mp == 4'd0 || mp != mlen) begin
								ph = PH_FIN; emit = 1'b1;
							end else tp = 3'd1;
						end else if (mp == 4'd0) begin
							if (lb == "g") begin post = 1'b0; mp = 4'd1; end
							else if (lb == "p") begin post = 1'b1; mp = 4'd1; end
							else begin ph = PH_FIN; emit = 1'b1; end
						end else if (mp >= mlen || lb != mpat) begin
							ph = PH_FIN; emit = 1'b1;
						end else mp = mp + 4'd1;
					end
					3'd1: begin
						if (bl) begin
						end else if (b == "/") begin
							tp = 3'd4; emit = 1'b1; kind = EV_URL; pay = b;
						end else if (lb == "h") begin
							tp = 3'd2; mp = 4'd1;
						end else begin ph = PH_FIN; emit = 1'b1; end
					end
					3'd2: begin
						if (mp == 4'd4) begin
							if (lb == "s") mp = 4'd5;
							else if (b == ":") mp = 4'd6;
							else begin ph = PH_FIN; emit = 1'b1; end
						end else if (mp >= 4'd8 || lb != pat_scheme(mp)) begin
							ph = PH_FIN; emit = 1'b1;
						end else begin
							mp = mp + 4'd1;
							if (mp == 4'd8) tp = 3'd3;
						end
					end
					3'd3: begin
						if (b == "/") begin
							tp = 3'd4; emit = 1'b1; kind = EV_URL; pay = b;
						end else if (bl) begin ph = PH_FIN; emit = 1'b1; end
					end
					3'd4: begin
						if (bl) begin tp = 3'd5; mp = 4'd0; end
						else begin emit = 1'b1; kind = EV_URL; pay = b; end
					end
					default: begin
						if (tp == 3'd5 && bl) begin
						end else begin
							if (tp == 3'd5) begin tp = 3'd6; mp = 4'd0; end
							if (mp >= 4'd8 || lb != pat_ver(mp)) begin
								ph = PH_FIN; emit = 1'b1;
							end else mp = mp + 4'd1;
						end
					end
				endcase
			end else begin
				hlen = hk == 2'd1 ? 4'd11 : 4'd15;
				hpat = hk == 2'd1 ? pat_conn(mp) : pat_clen(mp);
				prod = {4'd0, clen} * 24'd10 + {16'd0, b - 8'h30};
				if (tp == 3'd0) begin
					if (mp < 4'd3) begin
						if (lb != pat_conn(mp)) tp = 3'd3;
						else mp = mp + 4'd1;
					end else if (mp == 4'd3 && hk == 2'd0) begin
						if (lb == "n") begin hk = 2'd1; mp = 4'd4; end
						else if (lb == "t") begin hk = 2'd2; mp = 4'd4; end
						else tp = 3'd3;
					end else if (mp >= hlen || lb != hpat) begin
						tp = 3'd3;
					end else begin
						mp = mp + 4'd1;
						if (mp == hlen) begin
							tp = 3'd1; mp = 4'd0;
							if (hk == 2'd2) clen = 20'd0;
						end
					end
				end else if (tp == 3'd3) begin
				end else if (hk == 2'd1) begin
					if (tp == 3'd1 && bl) begin
					end else begin
						tp = 3'd2;
						if (mp >= 4'd10 || lb != pat_keep(mp)) tp = 3'd3;
						else mp = mp + 4'd1;
					end
				end else if (b >= "0" && b <= "9") begin
					if (tp == 3'd1) prod = {16'd0, b - 8'h30};
					clen = prod > {4'd0, MaxLen} ? MaxLen : prod[19:0];
					tp = 3'd2;
				end else if (tp == 3'd1 && (bl || b == 8'd11 || b == 8'd12)) begin
				end else if (tp == 3'd1 && b == "+") begin
					tp = 3'd2;
				end else tp = 3'd3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q.event_kind   <= kind;
			out_q.payload_byte <= pay;
			out_q.is_post      <= post;
			out_q.keep_alive   <= ka;
			out_q.body_length  <= clen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LINE; tp_q <= 3'd0; mp_q <= 4'd0; hk_q <= 2'd0; cr_q <= 1'b0;
			post_q <= 1'b0; ka_q <= 1'b0; clen_q <= 20'd0; rem_q <= 20'd0;
			cnt_q <= '0; out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				ph_q <= ph; tp_q <= tp; mp_q <= mp; hk_q <= hk; cr_q <= cr;
				post_q <= post; ka_q <= ka; clen_q <= clen; rem_q <= rem; cnt_q <= cnt;
			end
			if (q_pop) out_valid_q <= emit;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result lost");
	a_body_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_BODY |-> rem_q != 20'd0) else $error("body with nothing left");
	a_cnt_lim: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_REQUEST_BYTES)) else $error("byte count past limit");

endmodule

// ===== design/http_request_stream_parser_top.sv =====
// Top level of the HTTP/1.1 request stream parser.
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_data  (in_item_t)
//  output  | out_valid | out_stall | out_data (out_item_t)
// One byte per cycle sustained while out_stall is low; a byte passes the front queue, then the back output register.
// The front holds bytes in a two-entry queue; the back state machine takes one per cycle unless stalled.
// A result waits in the output register; the back stalls only when it is full and stalled.
// Reset returns the parser to the request-line state with all counts cleared.
module http_request_stream_parser_top
	import hrsp_pkg::*;
#(
	parameter int MAX_REQUEST_BYTES = MaxRequestBytesDef,
	parameter int MAX_BODY_LENGTH   = MaxBodyLengthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      q_valid, q_pop;
	cls_item_t q_data;

	hrsp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	hrsp_back #(
		.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES), .MAX_BODY_LENGTH(MAX_BODY_LENGTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
